// ----- rtl/ntc_pkg.sv -----
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared constants, the thermistor ratio/temperature table and the request
// and response structs of the shared divider.
// ----------------------------------------------------------------------------
package ntc_pkg;

  // Table geometry
  localparam int TABLE_POINTS = 33;
  localparam int TBL_IDX_W    = 6;
  localparam int TBL_R_W      = 23;   // ratio in units of 1e-6
  localparam int TBL_T_W      = 9;    // signed degrees C

  // Datapath widths
  localparam int RES_W   = 30;        // signed ohms before saturation
  localparam int RATIO_W = 50;        // signed ratio in units of 1e-6
  localparam int MAG_W   = 48;        // ratio / product magnitudes
  localparam int DVD_W   = 64;        // divider dividend
  localparam int DSR_W   = 23;        // divider divisor
  localparam int DIV_IDX_W = 6;

  // Arithmetic constants
  localparam logic [DVD_W-1:0] VOLT_NUMERATOR = 64'd268697600;  // 4100 * 65536
  localparam logic [19:0]      INNER_RES      = 20'd1000;
  localparam logic [19:0]      FIXED_PRE_RES  = 20'd10000;
  localparam logic [19:0]      RATIO_SCALE    = 20'd1000000;
  localparam logic [19:0]      CFG_RESET      = 20'd10000;
  localparam logic [DIV_IDX_W-1:0] VOLT_TOP_BIT  = 6'd28;
  localparam logic [DIV_IDX_W-1:0] RATIO_TOP_BIT = 6'd47;
  localparam logic [DIV_IDX_W-1:0] TEMP_TOP_BIT  = 6'd63;

  localparam logic signed [16:0] TEMP_MIN = -17'sd65536;
  localparam logic signed [16:0] TEMP_MAX = 17'sd65535;
  localparam logic signed [20:0] RES_MIN  = -21'sd100000;
  localparam logic signed [20:0] RES_MAX  = 21'sd1000000;

  // Codes
  localparam logic [1:0] REG_PRE_MOD = 2'd0;
  localparam logic [1:0] REG_PRE_AMP = 2'd1;
  localparam logic [1:0] REG_NOMINAL = 2'd2;

  localparam logic       MODE_VOLT = 1'b0;
  localparam logic       MODE_RES  = 1'b1;

  localparam logic [1:0] CH_MOD = 2'd0;
  localparam logic [1:0] CH_AMP = 2'd1;

  localparam logic [1:0] STAT_TABLE  = 2'd0;
  localparam logic [1:0] STAT_EXTRAP = 2'd1;
  localparam logic [1:0] STAT_ZERO_V = 2'd2;

  // Divider handshake
  typedef struct packed {
    logic                 start;
    logic [DVD_W-1:0]     dividend;
    logic [DSR_W-1:0]     divisor;
    logic [DIV_IDX_W-1:0] top_bit;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Ratio column of the table
  function automatic logic [TBL_R_W-1:0] tbl_ratio(input logic [TBL_IDX_W-1:0] idx);
    logic [TBL_R_W-1:0] r;
    case (idx)
      6'd0:  r = 23'd30166;
      6'd1:  r = 23'd33451;
      6'd2:  r = 23'd37179;
      6'd3:  r = 23'd41420;
      6'd4:  r = 23'd46259;
      6'd5:  r = 23'd51794;
      6'd6:  r = 23'd58144;
      6'd7:  r = 23'd65450;
      6'd8:  r = 23'd73881;
      6'd9:  r = 23'd83640;
      6'd10: r = 23'd94973;
      6'd11: r = 23'd108180;
      6'd12: r = 23'd123620;
      6'd13: r = 23'd141740;
      6'd14: r = 23'd163070;
      6'd15: r = 23'd188300;
      6'd16: r = 23'd218240;
      6'd17: r = 23'd253920;
      6'd18: r = 23'd296630;
      6'd19: r = 23'd347980;
      6'd20: r = 23'd410000;
      6'd21: r = 23'd485250;
      6'd22: r = 23'd577030;
      6'd23: r = 23'd689500;
      6'd24: r = 23'd821800;
      6'd25: r = 23'd1000000;
      6'd26: r = 23'd1214200;
      6'd27: r = 23'd1482700;
      6'd28: r = 23'd1821600;
      6'd29: r = 23'd2252000;
      6'd30: r = 23'd2802400;
      6'd31: r = 23'd3845200;
      6'd32: r = 23'd5529700;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Temperature column of the table
  function automatic logic signed [TBL_T_W-1:0] tbl_deg(input logic [TBL_IDX_W-1:0] idx);
    logic signed [TBL_T_W-1:0] t;
    case (idx)
      6'd0:  t = 9'sd150;
      6'd1:  t = 9'sd145;
      6'd2:  t = 9'sd140;
      6'd3:  t = 9'sd135;
      6'd4:  t = 9'sd130;
      6'd5:  t = 9'sd125;
      6'd6:  t = 9'sd120;
      6'd7:  t = 9'sd115;
      6'd8:  t = 9'sd110;
      6'd9:  t = 9'sd105;
      6'd10: t = 9'sd100;
      6'd11: t = 9'sd95;
      6'd12: t = 9'sd90;
      6'd13: t = 9'sd85;
      6'd14: t = 9'sd80;
      6'd15: t = 9'sd75;
      6'd16: t = 9'sd70;
      6'd17: t = 9'sd65;
      6'd18: t = 9'sd60;
      6'd19: t = 9'sd55;
      6'd20: t = 9'sd50;
      6'd21: t = 9'sd45;
      6'd22: t = 9'sd40;
      6'd23: t = 9'sd35;
      6'd24: t = 9'sd30;
      6'd25: t = 9'sd25;
      6'd26: t = 9'sd20;
      6'd27: t = 9'sd15;
      6'd28: t = 9'sd10;
      6'd29: t = 9'sd5;
      6'd30: t = 9'sd0;
      6'd31: t = -9'sd50;
      6'd32: t = -9'sd100;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/ntc_div.sv -----
// ----------------------------------------------------------------------------
// ntc_div
// Restoring unsigned divider, one quotient bit per cycle, starting at a
// caller-chosen top dividend bit. Shared by all three divisions.
// ----------------------------------------------------------------------------
module ntc_div (
  input  logic              clk,
  input  logic              rst,
  input  ntc_pkg::div_req_t req,
  output ntc_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [ntc_pkg::DIV_IDX_W-1:0] bit_idx;
  logic [ntc_pkg::DVD_W-1:0]     dvd;
  logic [ntc_pkg::DSR_W-1:0]     dsr;
  logic [ntc_pkg::DSR_W-1:0]     rem;
  logic [ntc_pkg::DVD_W-1:0]     quo;

  logic [ntc_pkg::DSR_W:0] shifted;
  logic [ntc_pkg::DSR_W:0] trial;
  logic                    take;

  assign shifted = {rem, dvd[bit_idx]};
  assign trial   = shifted - {1'b0, dsr};
  assign take    = !trial[ntc_pkg::DSR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        bit_idx <= req.top_bit;
        dvd     <= req.dividend;
        dsr     <= req.divisor;
        rem     <= '0;
        quo     <= '0;
      end else if (busy) begin
        rem <= take ? trial[ntc_pkg::DSR_W-1:0] : shifted[ntc_pkg::DSR_W-1:0];
        quo <= {quo[ntc_pkg::DVD_W-2:0], take};
        if (bit_idx == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          bit_idx <= bit_idx - 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- rtl/ntc_thermistor_temperature.sv -----
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature
// Converts a divider voltage or a direct resistance into an NTC thermistor
// temperature by table search and linear interpolation.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                    Direction
//  --------  -----------------------------------------  ---------
//  input     in_valid, in_stall, mode, channel,          in
//            volt_in, res_in
//  output    out_valid, out_stall, temperature,          out
//            resistance, status
//  config    cfg_wr_en, cfg_index, cfg_data              in
//
//  One transaction at a time. Resistance mode runs two divisions, voltage
//  mode three, with a scan of s (1..32) table segments before the last one;
//  the one-bit-per-cycle shared divider computes 29, 48 and 64 quotient
//  bits for the three divisions.
//  Zero voltage goes straight to finish. Reset (rst, synchronous) empties the
//  output register and restores the configuration to 10000 ohm each.
//  A stalled result holds in the output register; the next input
//  transaction is taken once the finished one has moved there.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [1:0]         channel,
  input  logic [18:0]        volt_in,
  input  logic signed [20:0] res_in,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] temperature,
  output logic signed [20:0] resistance,
  output logic [1:0]         status
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIV_V  = 8'b0000_0010,
    S_MUL_R  = 8'b0000_0100,
    S_DIV_R  = 8'b0000_1000,
    S_SEARCH = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_DIV_T  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [19:0] pre_res_mod;
  logic [19:0] pre_res_amp;
  logic [19:0] nominal_res;

  // shared divider
  ntc_pkg::div_req_t div_req;
  ntc_pkg::div_rsp_t div_rsp;

  ntc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // datapath registers
  logic [19:0]                         pre_sel;
  logic signed [ntc_pkg::RES_W-1:0]    res;
  logic signed [ntc_pkg::RATIO_W-1:0]  ratio;
  logic [ntc_pkg::TBL_IDX_W-1:0]       idx;
  logic [ntc_pkg::MAG_W-1:0]           diff_mag;
  logic                                diff_neg;
  logic [7:0]                          dt_mag;
  logic                                dt_neg;
  logic [ntc_pkg::TBL_R_W-1:0]         dr;
  logic signed [16:0]                  base;
  logic                                extrap;
  logic signed [16:0]                  temp_r;
  logic [1:0]                          status_r;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic                                accept;
  logic                                div_go;
  logic                                load_out;
  logic [ntc_pkg::RES_W-1:0]           res_mag;
  logic [48:0]                         ratio_prod;
  logic [19:0]                         nom_eff;
  logic [ntc_pkg::TBL_IDX_W-1:0]       idx_prev;
  logic signed [ntc_pkg::RATIO_W-1:0]  r_cur;
  logic signed [ntc_pkg::RATIO_W-1:0]  r_prev;
  logic signed [ntc_pkg::RATIO_W-1:0]  r_first;
  logic signed [ntc_pkg::RATIO_W-1:0]  r_last;
  logic                                seg_hit;
  logic signed [ntc_pkg::RATIO_W-1:0]  diff;
  logic signed [ntc_pkg::TBL_T_W:0]    dt;
  logic [55:0]                         num_prod;
  logic                                q_neg;
  logic                                q_big;
  logic signed [19:0]                  q_signed;
  logic signed [19:0]                  temp_sum;
  logic signed [20:0]                  res_sat;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // start a division on a nonzero voltage, after the ratio product and
  // before the interpolation quotient of a sloped segment
  assign div_go   = ((state == S_IDLE) && accept && (mode == ntc_pkg::MODE_VOLT) &&
                     (volt_in != '0)) ||
                    (state == S_MUL_R) ||
                    ((state == S_MUL) && (dr != '0));
  assign load_out = (state == S_FINISH) && (!out_valid || !out_stall);

  assign res_mag    = res[ntc_pkg::RES_W-1] ? ntc_pkg::RES_W'(-res) : ntc_pkg::RES_W'(res);
  assign ratio_prod = 49'(res_mag[28:0]) * 49'(ntc_pkg::RATIO_SCALE);
  assign nom_eff    = (nominal_res == '0) ? 20'd1 : nominal_res;

  assign idx_prev = idx - 1'b1;
  assign r_cur    = $signed(ntc_pkg::RATIO_W'(ntc_pkg::tbl_ratio(idx)));
  assign r_prev   = $signed(ntc_pkg::RATIO_W'(ntc_pkg::tbl_ratio(idx_prev)));
  assign r_first  = $signed(ntc_pkg::RATIO_W'(ntc_pkg::tbl_ratio('0)));
  assign r_last   = $signed(ntc_pkg::RATIO_W'(
                      ntc_pkg::tbl_ratio(ntc_pkg::TBL_IDX_W'(ntc_pkg::TABLE_POINTS - 1))));
  assign seg_hit  = (ratio < r_cur) || (idx == ntc_pkg::TBL_IDX_W'(ntc_pkg::TABLE_POINTS - 1));
  assign diff     = ratio - r_prev;
  assign dt       = ntc_pkg::tbl_deg(idx) - ntc_pkg::tbl_deg(idx_prev);

  // |ratio - r| * |dT|; the factor 256 is a shift below
  assign num_prod = 56'(diff_mag) * 56'(dt_mag);

  // interpolation quotient: anything past 18 bits saturates the result
  assign q_neg    = diff_neg ^ dt_neg;
  assign q_big    = |div_rsp.quotient[ntc_pkg::DVD_W-1:18];
  assign q_signed = q_neg ? -$signed({2'b00, div_rsp.quotient[17:0]})
                          :  $signed({2'b00, div_rsp.quotient[17:0]});
  assign temp_sum = 20'(base) + q_signed;

  always_comb begin
    if (res < ntc_pkg::RES_W'(ntc_pkg::RES_MIN)) begin
      res_sat = ntc_pkg::RES_MIN;
    end else if (res > ntc_pkg::RES_W'(ntc_pkg::RES_MAX)) begin
      res_sat = ntc_pkg::RES_MAX;
    end else begin
      res_sat = res[20:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pre_res_mod <= ntc_pkg::CFG_RESET;
      pre_res_amp <= ntc_pkg::CFG_RESET;
      nominal_res <= ntc_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ntc_pkg::REG_PRE_MOD: pre_res_mod <= cfg_data;
        ntc_pkg::REG_PRE_AMP: pre_res_amp <= cfg_data;
        ntc_pkg::REG_NOMINAL: nominal_res <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      div_req.start <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // one-cycle start pulse per division
      div_req.start <= div_go;

      // load a finished transaction, hold a stalled one, drop a taken one
      out_valid     <= load_out || (out_valid && out_stall);

      case (state)
        S_IDLE: begin
          if (accept) begin
            if (mode == ntc_pkg::MODE_RES) begin
              res   <= ntc_pkg::RES_W'(res_in);
              state <= S_MUL_R;
            end else if (volt_in == '0) begin
              // zero voltage: report open circuit directly
              res      <= ntc_pkg::RES_W'(ntc_pkg::RES_MAX);
              temp_r   <= ntc_pkg::TEMP_MIN;
              status_r <= ntc_pkg::STAT_ZERO_V;
              state    <= S_FINISH;
            end else begin
              case (channel)
                ntc_pkg::CH_MOD: pre_sel <= pre_res_mod;
                ntc_pkg::CH_AMP: pre_sel <= pre_res_amp;
                default:         pre_sel <= ntc_pkg::FIXED_PRE_RES;
              endcase
              div_req.dividend <= ntc_pkg::VOLT_NUMERATOR;
              div_req.divisor  <= ntc_pkg::DSR_W'(volt_in);
              div_req.top_bit  <= ntc_pkg::VOLT_TOP_BIT;
              state            <= S_DIV_V;
            end
          end
        end

        S_DIV_V: begin
          if (div_rsp.done) begin
            res   <= $signed({1'b0, div_rsp.quotient[28:0]})
                     - $signed(ntc_pkg::RES_W'(ntc_pkg::INNER_RES))
                     - $signed(ntc_pkg::RES_W'(pre_sel));
            state <= S_MUL_R;
          end
        end

        S_MUL_R: begin
          // |R| * 1e6 / nominal, sign restored afterwards
          div_req.dividend <= ntc_pkg::DVD_W'(ratio_prod);
          div_req.divisor  <= ntc_pkg::DSR_W'(nom_eff);
          div_req.top_bit  <= ntc_pkg::RATIO_TOP_BIT;
          state            <= S_DIV_R;
        end

        S_DIV_R: begin
          if (div_rsp.done) begin
            if (res[ntc_pkg::RES_W-1]) begin
              ratio <= -$signed({2'b00, div_rsp.quotient[ntc_pkg::MAG_W-1:0]});
            end else begin
              ratio <= $signed({2'b00, div_rsp.quotient[ntc_pkg::MAG_W-1:0]});
            end
            idx   <= ntc_pkg::TBL_IDX_W'(1);
            state <= S_SEARCH;
          end
        end

        S_SEARCH: begin
          // scan for the first point whose ratio exceeds the input, else the last
          if (seg_hit) begin
            diff_neg <= diff[ntc_pkg::RATIO_W-1];
            diff_mag <= diff[ntc_pkg::RATIO_W-1] ? ntc_pkg::MAG_W'(-diff)
                                                 : ntc_pkg::MAG_W'(diff);
            dt_neg   <= dt[ntc_pkg::TBL_T_W];
            dt_mag   <= dt[ntc_pkg::TBL_T_W] ? 8'(-dt) : 8'(dt);
            dr       <= ntc_pkg::tbl_ratio(idx) - ntc_pkg::tbl_ratio(idx_prev);
            base     <= $signed({ntc_pkg::tbl_deg(idx_prev), 8'h00});
            extrap   <= (ratio < r_first) || (ratio > r_last);
            state    <= S_MUL;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_MUL: begin
          if (dr == '0) begin
            // flat segment: take the earlier point's temperature
            temp_r   <= base;
            status_r <= extrap ? ntc_pkg::STAT_EXTRAP : ntc_pkg::STAT_TABLE;
            state    <= S_FINISH;
          end else begin
            div_req.dividend <= {num_prod, 8'h00};
            div_req.divisor  <= dr;
            div_req.top_bit  <= ntc_pkg::TEMP_TOP_BIT;
            state            <= S_DIV_T;
          end
        end

        S_DIV_T: begin
          if (div_rsp.done) begin
            if (q_big) begin
              temp_r <= q_neg ? ntc_pkg::TEMP_MIN : ntc_pkg::TEMP_MAX;
            end else if (temp_sum < 20'(ntc_pkg::TEMP_MIN)) begin
              temp_r <= ntc_pkg::TEMP_MIN;
            end else if (temp_sum > 20'(ntc_pkg::TEMP_MAX)) begin
              temp_r <= ntc_pkg::TEMP_MAX;
            end else begin
              temp_r <= temp_sum[16:0];
            end
            status_r <= extrap ? ntc_pkg::STAT_EXTRAP : ntc_pkg::STAT_TABLE;
            state    <= S_FINISH;
          end
        end

        S_FINISH: begin
          // hand over once the output register is free or draining
          if (load_out) begin
            temperature <= temp_r;
            resistance  <= res_sat;
            status      <= status_r;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_search_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> (idx != '0) &&
                          (idx < ntc_pkg::TBL_IDX_W'(ntc_pkg::TABLE_POINTS)))
    else $error("table scan index out of range");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) && (!out_valid || !out_stall) |=> out_valid && (state == S_IDLE))
    else $error("finished result not loaded");

  a_zero_volt_temp: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ntc_pkg::STAT_ZERO_V) |->
      (temperature == ntc_pkg::TEMP_MIN) && (resistance == ntc_pkg::RES_MAX))
    else $error("zero-voltage result malformed");

endmodule

// ----- sim/ntc_thermistor_temperature_checker.sv -----
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature_checker
// Watches the configuration port and both channels of the thermistor block,
// predicts each reading from the accepted measurement and compares it field
// by field with what the block delivers.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               mode,
  input  logic [1:0]         channel,
  input  logic [18:0]        volt_in,
  input  logic signed [20:0] res_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [16:0] temperature,
  input  logic signed [20:0] resistance,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [16:0] temperature;
    logic signed [20:0] resistance;
    logic [1:0]         status;
  } reading_t;

  localparam int     SEGS        = 33;
  localparam longint DIVIDEND    = 268697600;  // 4100 ohm-volts in 1/65536 V
  localparam longint INNER_OHMS  = 1000;
  localparam longint FIXED_OHMS  = 10000;
  localparam longint PPM         = 1000000;
  localparam longint T_LO        = -65536;
  localparam longint T_HI        = 65535;
  localparam longint R_LO        = -100000;
  localparam longint R_HI        = 1000000;

  // Ratio (1e-6 units) and degrees C of each curve point, hot to cold
  longint ratio_pts [SEGS] = '{
    30166, 33451, 37179, 41420, 46259, 51794, 58144, 65450, 73881, 83640,
    94973, 108180, 123620, 141740, 163070, 188300, 218240, 253920, 296630,
    347980, 410000, 485250, 577030, 689500, 821800, 1000000, 1214200,
    1482700, 1821600, 2252000, 2802400, 3845200, 5529700};
  longint deg_pts [SEGS] = '{
    150, 145, 140, 135, 130, 125, 120, 115, 110, 105, 100, 95, 90, 85, 80,
    75, 70, 65, 60, 55, 50, 45, 40, 35, 30, 25, 20, 15, 10, 5, 0, -50, -100};

  logic [19:0] pre_mod_ohms = ntc_pkg::CFG_RESET;
  logic [19:0] pre_amp_ohms = ntc_pkg::CFG_RESET;
  logic [19:0] nominal_ohms = ntc_pkg::CFG_RESET;
  reading_t    expected_readings [$];
  reading_t    want;
  int          mismatches = 0;

  function automatic reading_t predict_reading(input logic m, input logic [1:0] ch,
                                               input logic [18:0] v,
                                               input logic signed [20:0] r);
    reading_t rd;
    longint   ohms, pre, nom, ratio, dr, dt, t;
    int       seg;
    logic     found;
    if (m == ntc_pkg::MODE_VOLT && v == '0) begin
      rd.temperature = ntc_pkg::TEMP_MIN;
      rd.resistance  = ntc_pkg::RES_MAX;
      rd.status      = ntc_pkg::STAT_ZERO_V;
      return rd;
    end
    if (m == ntc_pkg::MODE_VOLT) begin
      case (ch)
        ntc_pkg::CH_MOD: pre = longint'(pre_mod_ohms);
        ntc_pkg::CH_AMP: pre = longint'(pre_amp_ohms);
        default:         pre = FIXED_OHMS;
      endcase
      ohms = DIVIDEND / longint'(v) - INNER_OHMS - pre;
    end else begin
      ohms = longint'(r);
    end
    nom   = (nominal_ohms == '0) ? 1 : longint'(nominal_ohms);
    ratio = ohms * PPM / nom;
    // first segment whose upper point lies above the ratio, else the last
    seg   = SEGS - 1;
    found = 1'b0;
    for (int i = 1; i < SEGS; i++) begin
      if (!found && ratio < ratio_pts[i]) begin
        seg   = i;
        found = 1'b1;
      end
    end
    dr = ratio_pts[seg] - ratio_pts[seg-1];
    if (dr == 0) begin
      t = deg_pts[seg-1] * 256;
    end else begin
      dt = (deg_pts[seg] - deg_pts[seg-1]) * 256;
      t  = deg_pts[seg-1] * 256 + (ratio - ratio_pts[seg-1]) * dt / dr;
    end
    if (t < T_LO) t = T_LO;
    if (t > T_HI) t = T_HI;
    if (ohms < R_LO) ohms = R_LO;
    if (ohms > R_HI) ohms = R_HI;
    rd.temperature = t[16:0];
    rd.resistance  = ohms[20:0];
    rd.status      = (ratio < ratio_pts[0] || ratio > ratio_pts[SEGS-1]) ?
                     ntc_pkg::STAT_EXTRAP : ntc_pkg::STAT_TABLE;
    return rd;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pre_mod_ohms = ntc_pkg::CFG_RESET;
      pre_amp_ohms = ntc_pkg::CFG_RESET;
      nominal_ohms = ntc_pkg::CFG_RESET;
      expected_readings.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          ntc_pkg::REG_PRE_MOD: pre_mod_ohms = cfg_data;
          ntc_pkg::REG_PRE_AMP: pre_amp_ohms = cfg_data;
          ntc_pkg::REG_NOMINAL: nominal_ohms = cfg_data;
          default: ;
        endcase
      end
      // retire the oldest reading before queuing a new one
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: reading with none expected: temperature %0d resistance %0d status %0d",
                   $time, temperature, resistance, status);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (temperature !== want.temperature) begin
            $display("%0t: temperature expected %0d actual %0d",
                     $time, want.temperature, temperature);
            mismatches++;
          end
          if (resistance !== want.resistance) begin
            $display("%0t: resistance expected %0d actual %0d",
                     $time, want.resistance, resistance);
            mismatches++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_readings.push_back(predict_reading(mode, channel, volt_in, res_in));
    end
    fail_count <= mismatches;
    pending    <= expected_readings.size();
  end

endmodule

// ----- sim/ntc_thermistor_temperature_test.sv -----
// ----------------------------------------------------------------------------
// ntc_thermistor_temperature_test
// Drives measurements into the thermistor block under several register
// settings, with random gaps and output back-pressure, and reports the
// verdict from the failure count of the checker beside the block.
// ----------------------------------------------------------------------------
module ntc_thermistor_temperature_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Sized for 500-odd items at the slowest conversion with the largest gaps
  // and stalls, with a margin of several times that.
  localparam int CYCLE_LIMIT = 800000;
  localparam int LONG_HOLD   = 600;
  localparam int TAIL_CYCLES = 250;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [1:0]         cfg_index;
  logic [19:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               mode;
  logic [1:0]         channel;
  logic [18:0]        volt_in;
  logic signed [20:0] res_in;
  logic               out_valid;
  logic               out_stall;
  logic signed [16:0] temperature;
  logic signed [20:0] resistance;
  logic [1:0]         status;

  int fail_count;
  int pending;
  int cycle_count  = 0;
  int stall_len;
  bit idle_on      = 1'b1;
  bit hold_request = 1'b0;

  // Register values as last written, used only to aim stimulus into the table
  logic [19:0] cur_pre_mod = ntc_pkg::CFG_RESET;
  logic [19:0] cur_pre_amp = ntc_pkg::CFG_RESET;
  logic [19:0] cur_nominal = ntc_pkg::CFG_RESET;

  ntc_thermistor_temperature i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .channel     (channel),
    .volt_in     (volt_in),
    .res_in      (res_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .temperature (temperature),
    .resistance  (resistance),
    .status      (status)
  );

  ntc_thermistor_temperature_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ntc_thermistor_temperature verification failed");
      $finish;
    end
  end

  // Result side: draw a stall per reading, then take the next one. A hold
  // request parks the output long enough for the block to back up.
  initial begin
    out_stall = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        stall_len    = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        stall_len = idle_on ? int'($urandom_range(0, 5)) : 0;
      end
      if (stall_len > 0) begin
        out_stall = 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Write one register at a falling edge; only called with the block idle
  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      ntc_pkg::REG_PRE_MOD: cur_pre_mod = val;
      ntc_pkg::REG_PRE_AMP: cur_pre_amp = val;
      ntc_pkg::REG_NOMINAL: cur_nominal = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Offer one measurement after a random gap; return at the accepting edge
  task automatic send_item(input logic m, input logic [1:0] ch, input logic [18:0] v,
                           input logic signed [20:0] r);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 5)) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    mode     = m;
    channel  = ch;
    volt_in  = v;
    res_in   = r;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every queued reading has come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly measurements aimed at a ratio near the curve (slightly past both
  // ends too), the rest raw bit patterns and the odd zero voltage.
  task automatic run_random(input int count);
    logic               m;
    logic [1:0]         ch;
    logic [18:0]        v;
    logic signed [20:0] r;
    longint             nom, target, pre, den, q;
    for (int k = 0; k < count; k++) begin
      m  = 1'($urandom_range(0, 1));
      ch = 2'($urandom_range(0, 3));
      v  = 19'($urandom);
      r  = 21'($urandom);
      if ($urandom_range(0, 9) < 7) begin
        nom    = (cur_nominal == '0) ? 1 : longint'(cur_nominal);
        target = longint'($urandom_range(25000, 6000000)) * nom / 1000000;
        if (m == ntc_pkg::MODE_RES) begin
          if (target <= 1048575) r = target[20:0];
        end else begin
          case (ch)
            ntc_pkg::CH_MOD: pre = longint'(cur_pre_mod);
            ntc_pkg::CH_AMP: pre = longint'(cur_pre_amp);
            default:         pre = 10000;
          endcase
          den = target + 1000 + pre;
          if (den > 0) begin
            q = 268697600 / den;
            if (q > 0 && q < 524288) v = q[18:0];
          end
        end
      end else if ($urandom_range(0, 19) == 0) begin
        v = '0;
      end
      send_item(m, ch, v, r);
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = ntc_pkg::REG_PRE_MOD;
    cfg_data  = '0;
    in_valid  = 1'b0;
    mode      = ntc_pkg::MODE_VOLT;
    channel   = ntc_pkg::CH_MOD;
    volt_in   = '0;
    res_in    = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed pass at reset settings
    send_item(ntc_pkg::MODE_VOLT, ntc_pkg::CH_MOD, 19'd0, 21'sd0);      // zero voltage
    send_item(ntc_pkg::MODE_VOLT, 2'd3, 19'd0, -21'sd1);       // zero voltage, channel three
    send_item(ntc_pkg::MODE_VOLT, ntc_pkg::CH_MOD, 19'd12795, 21'sd0);  // near 25 C
    send_item(ntc_pkg::MODE_VOLT, ntc_pkg::CH_AMP, 19'd8000, 21'sd0);
    send_item(ntc_pkg::MODE_VOLT, ntc_pkg::CH_MOD, 19'd40000, 21'sd0);
    send_item(ntc_pkg::MODE_VOLT, ntc_pkg::CH_AMP, 19'd1, 21'sd0);      // huge resistance
    send_item(ntc_pkg::MODE_VOLT, 2'd2, 19'h7FFFF, 21'sd0);    // full-scale, negative R
    send_item(ntc_pkg::MODE_VOLT, 2'd3, 19'd327679, 21'sd0);   // top of the nominal range
    send_item(ntc_pkg::MODE_RES, ntc_pkg::CH_MOD, 19'd0, 21'sd10000);   // exact 25 C point
    send_item(ntc_pkg::MODE_RES, ntc_pkg::CH_AMP, 19'd0, 21'sd0);       // zero resistance
    send_item(ntc_pkg::MODE_RES, 2'd2, 19'h7FFFF, -21'sd100000);
    send_item(ntc_pkg::MODE_RES, 2'd3, 19'd5, -21'sd1048576);  // most negative field
    send_item(ntc_pkg::MODE_RES, ntc_pkg::CH_MOD, 19'd0, 21'sd1048575); // most positive field
    send_item(ntc_pkg::MODE_RES, ntc_pkg::CH_AMP, 19'd77, 21'sd1000000);
    send_item(ntc_pkg::MODE_RES, ntc_pkg::CH_MOD, 19'd0, 21'sd301);     // just below hot end
    send_item(ntc_pkg::MODE_RES, ntc_pkg::CH_MOD, 19'd0, 21'sd302);     // first segment
    send_item(ntc_pkg::MODE_RES, ntc_pkg::CH_MOD, 19'd0, 21'sd55297);   // exact cold end
    send_item(ntc_pkg::MODE_RES, ntc_pkg::CH_MOD, 19'd0, 21'sd55298);   // past the cold end
    send_item(ntc_pkg::MODE_RES, ntc_pkg::CH_AMP, 19'd0, 21'sd30000);
    send_item(ntc_pkg::MODE_RES, 2'd3, 19'd0, 21'sd1500);      // zero volt ignored here
    send_item(ntc_pkg::MODE_RES, 2'd2, 19'd123, 21'sd4100);
    drain();

    // Register extremes, one way round
    write_reg(ntc_pkg::REG_PRE_MOD, 20'd0);
    write_reg(ntc_pkg::REG_PRE_AMP, 20'd1000000);
    write_reg(ntc_pkg::REG_NOMINAL, 20'd1000000);
    run_random(100);
    drain();

    // The other way round, with one long output hold
    hold_request = 1'b1;
    write_reg(ntc_pkg::REG_PRE_MOD, 20'd1000000);
    write_reg(ntc_pkg::REG_PRE_AMP, 20'd0);
    write_reg(ntc_pkg::REG_NOMINAL, 20'd1);
    run_random(100);
    drain();

    // Zero nominal resistance and all-ones pre-resistances, back to back
    idle_on = 1'b0;
    write_reg(ntc_pkg::REG_NOMINAL, 20'd0);
    write_reg(ntc_pkg::REG_PRE_MOD, 20'hFFFFF);
    write_reg(ntc_pkg::REG_PRE_AMP, 20'hFFFFF);
    run_random(60);
    drain();
    idle_on = 1'b1;

    // Arbitrary settings
    write_reg(ntc_pkg::REG_PRE_MOD, 20'($urandom_range(0, 1000000)));
    write_reg(ntc_pkg::REG_PRE_AMP, 20'($urandom_range(0, 1000000)));
    write_reg(ntc_pkg::REG_NOMINAL, 20'($urandom_range(1, 1000000)));
    run_random(100);
    drain();

    // Back to the usual divider
    write_reg(ntc_pkg::REG_PRE_MOD, ntc_pkg::CFG_RESET);
    write_reg(ntc_pkg::REG_PRE_AMP, ntc_pkg::CFG_RESET);
    write_reg(ntc_pkg::REG_NOMINAL, ntc_pkg::CFG_RESET);
    run_random(140);
    drain();

    // Let any stray reading show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ntc_thermistor_temperature verification clean");
    end else begin
      $display("ntc_thermistor_temperature verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ntc_pkg.sv
rtl/ntc_div.sv
rtl/ntc_thermistor_temperature.sv
sim/ntc_thermistor_temperature_checker.sv
sim/ntc_thermistor_temperature_test.sv
